// File: rtl/shlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seat heater level control package
// Shared widths, register map, reset values and mode codes for the block.
// ----------------------------------------------------------------------------
package shlc_pkg;

    // Field and register widths.
    localparam int unsigned TEMP_W  = 8;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned REG_IW  = 3;

    // Register indexes on the configuration port (byte address 4 * index).
    localparam logic [REG_IW-1:0] REG_TARGET_LOW    = 3'd0;
    localparam logic [REG_IW-1:0] REG_TARGET_MEDIUM = 3'd1;
    localparam logic [REG_IW-1:0] REG_TARGET_HIGH   = 3'd2;
    localparam logic [REG_IW-1:0] REG_MARGIN_HIGH   = 3'd3;
    localparam logic [REG_IW-1:0] REG_MARGIN_MEDIUM = 3'd4;
    localparam logic [REG_IW-1:0] REG_MARGIN_LOW    = 3'd5;

    // Register values after reset.
    localparam logic [TEMP_W-1:0] RST_TARGET_LOW    = 8'd25;
    localparam logic [TEMP_W-1:0] RST_TARGET_MEDIUM = 8'd30;
    localparam logic [TEMP_W-1:0] RST_TARGET_HIGH   = 8'd35;
    localparam logic [TEMP_W-1:0] RST_MARGIN_HIGH   = 8'd10;
    localparam logic [TEMP_W-1:0] RST_MARGIN_MEDIUM = 8'd5;
    localparam logic [TEMP_W-1:0] RST_MARGIN_LOW    = 8'd2;

    // Event kinds.
    localparam logic OP_BUTTON  = 1'b0;
    localparam logic OP_READING = 1'b1;

    // Heater mode and intensity codes share one encoding.
    typedef enum logic [LEVEL_W-1:0] {
        LVL_OFF    = 2'd0,
        LVL_LOW    = 2'd1,
        LVL_MEDIUM = 2'd2,
        LVL_HIGH   = 2'd3
    } level_t;

    // Configuration register set.
    typedef struct packed {
        logic [TEMP_W-1:0] target_low;
        logic [TEMP_W-1:0] target_medium;
        logic [TEMP_W-1:0] target_high;
        logic [TEMP_W-1:0] margin_high;
        logic [TEMP_W-1:0] margin_medium;
        logic [TEMP_W-1:0] margin_low;
    } cfg_t;

endpackage : shlc_pkg
`default_nettype wire

// File: rtl/seat_heater_level_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Seat heater level control
// Per-seat heater mode and temperature with a registered intensity result.
// ----------------------------------------------------------------------------
// Each accepted event updates its seat in the same cycle and its result
// word appears in the output register on the next edge, so the block takes
// one word per cycle unless stalled; the only limit is the single output
// register, which holds a word while out_stall is high. Events for a
// seat at or beyond SEAT_COUNT are taken and dropped without a result.
// Configuration registers sit on an APB port at byte address 4 * index and
// must be written while no word is in flight.
module seat_heater_level_control #(
    parameter int unsigned SEAT_COUNT = 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Event channel.
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 opcode,
    input  wire logic                                 seat_index,
    input  wire logic [shlc_pkg::TEMP_W-1:0]          reading,
    // Result channel.
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      seat_out,
    output logic [shlc_pkg::LEVEL_W-1:0]              mode_out,
    output logic [shlc_pkg::LEVEL_W-1:0]              heat_level,
    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [shlc_pkg::APB_AW-1:0]          paddr,
    input  wire logic [shlc_pkg::APB_DW-1:0]          pwdata,
    output logic [shlc_pkg::APB_DW-1:0]               prdata,
    output logic                                      pready
);

    localparam int unsigned SEAT_W = (SEAT_COUNT > 1) ? $clog2(SEAT_COUNT) : 1;

    // Configuration registers.
    shlc_pkg::cfg_t                   cfg_reg;
    logic [shlc_pkg::REG_IW-1:0]      reg_idx;
    logic                             cfg_wr;

    // Per-seat state.
    logic [shlc_pkg::LEVEL_W-1:0]     mode_reg [SEAT_COUNT];
    logic [shlc_pkg::TEMP_W-1:0]      temp_reg [SEAT_COUNT];

    // Event evaluation.
    logic                             in_accept;
    logic                             seat_ok;
    logic [SEAT_W-1:0]                seat_idx;
    logic [shlc_pkg::LEVEL_W-1:0]     mode_new;
    logic [shlc_pkg::TEMP_W-1:0]      temp_new;
    logic [shlc_pkg::TEMP_W-1:0]      goal;
    logic [shlc_pkg::TEMP_W-1:0]      shortfall;
    logic [shlc_pkg::LEVEL_W-1:0]     level_new;

    // Result register.
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             seat_out_reg;
    logic [shlc_pkg::LEVEL_W-1:0]     mode_out_reg;
    logic [shlc_pkg::LEVEL_W-1:0]     heat_level_reg;

    // The APB port never waits; writes land on the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[shlc_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_low    <= shlc_pkg::RST_TARGET_LOW;
            cfg_reg.target_medium <= shlc_pkg::RST_TARGET_MEDIUM;
            cfg_reg.target_high   <= shlc_pkg::RST_TARGET_HIGH;
            cfg_reg.margin_high   <= shlc_pkg::RST_MARGIN_HIGH;
            cfg_reg.margin_medium <= shlc_pkg::RST_MARGIN_MEDIUM;
            cfg_reg.margin_low    <= shlc_pkg::RST_MARGIN_LOW;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                shlc_pkg::REG_TARGET_LOW:    cfg_reg.target_low    <= pwdata[7:0];
                shlc_pkg::REG_TARGET_MEDIUM: cfg_reg.target_medium <= pwdata[7:0];
                shlc_pkg::REG_TARGET_HIGH:   cfg_reg.target_high   <= pwdata[7:0];
                shlc_pkg::REG_MARGIN_HIGH:   cfg_reg.margin_high   <= pwdata[7:0];
                shlc_pkg::REG_MARGIN_MEDIUM: cfg_reg.margin_medium <= pwdata[7:0];
                shlc_pkg::REG_MARGIN_LOW:    cfg_reg.margin_low    <= pwdata[7:0];
                default:                     ;
            endcase
        end
    end

    // Register read-back; unused addresses read as zero.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            shlc_pkg::REG_TARGET_LOW:    prdata[7:0] = cfg_reg.target_low;
            shlc_pkg::REG_TARGET_MEDIUM: prdata[7:0] = cfg_reg.target_medium;
            shlc_pkg::REG_TARGET_HIGH:   prdata[7:0] = cfg_reg.target_high;
            shlc_pkg::REG_MARGIN_HIGH:   prdata[7:0] = cfg_reg.margin_high;
            shlc_pkg::REG_MARGIN_MEDIUM: prdata[7:0] = cfg_reg.margin_medium;
            shlc_pkg::REG_MARGIN_LOW:    prdata[7:0] = cfg_reg.margin_low;
            default:                     prdata = '0;
        endcase
    end

    // Take a new word whenever the output register is empty or being drained.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Seat lookup and the updated mode and temperature.
    assign seat_ok  = ({31'd0, seat_index} < SEAT_COUNT);
    assign seat_idx = SEAT_W'(seat_index);

    always_comb
    begin
        mode_new = mode_reg[seat_idx];
        temp_new = temp_reg[seat_idx];
        if (opcode == shlc_pkg::OP_BUTTON)
        begin
            mode_new = mode_reg[seat_idx] + 2'd1;
        end
        else
        begin
            temp_new = reading;
        end
    end

    // Target of the updated mode.
    always_comb
    begin
        unique case (mode_new)
            shlc_pkg::LVL_LOW:    goal = cfg_reg.target_low;
            shlc_pkg::LVL_MEDIUM: goal = cfg_reg.target_medium;
            shlc_pkg::LVL_HIGH:   goal = cfg_reg.target_high;
            default:              goal = '0;
        endcase
    end

    // Intensity from the shortfall below the target; first margin met wins.
    assign shortfall = goal - temp_new;

    always_comb
    begin
        priority if (mode_new == shlc_pkg::LVL_OFF || temp_new >= goal)
        begin
            level_new = shlc_pkg::LVL_OFF;
        end
        else if (shortfall >= cfg_reg.margin_high)
        begin
            level_new = shlc_pkg::LVL_HIGH;
        end
        else if (shortfall >= cfg_reg.margin_medium)
        begin
            level_new = shlc_pkg::LVL_MEDIUM;
        end
        else if (shortfall >= cfg_reg.margin_low)
        begin
            level_new = shlc_pkg::LVL_LOW;
        end
        else
        begin
            level_new = shlc_pkg::LVL_OFF;
        end
    end

    // Seat state write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEAT_COUNT; i++)
            begin
                mode_reg[i] <= shlc_pkg::LVL_OFF;
                temp_reg[i] <= '0;
            end
        end
        else if (in_accept && seat_ok)
        begin
            mode_reg[seat_idx] <= mode_new;
            temp_reg[seat_idx] <= temp_new;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (in_accept && seat_ok)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload loads only with a new result word.
    always_ff @(posedge clk)
    begin
        if (in_accept && seat_ok)
        begin
            seat_out_reg   <= seat_index;
            mode_out_reg   <= mode_new;
            heat_level_reg <= level_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign seat_out   = seat_out_reg;
    assign mode_out   = mode_out_reg;
    assign heat_level = heat_level_reg;

endmodule : seat_heater_level_control
`default_nettype wire
